// ===== design/signed_int_to_radix_text_unit_assert.svh =====
// Assertion macros for the signed integer to radix text unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SIGNED_INT_TO_RADIX_TEXT_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_TEXT_UNIT_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SITRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitrt: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define SITRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitrt: next-cycle check failed");

`endif

// ===== design/sitrt_pkg.sv =====
// Shared types, constants and helper functions for the radix text unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sitrt_pkg;

    localparam int ALPHABET_BYTES_DEF = 64;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 64;
    localparam int VALUE_PORT_W       = 32;
    localparam int CHAR_W             = 8;
    localparam int DIV_STEPS          = 8;
    localparam int SLOT_COUNT         = 62;
    localparam int SLOT_W             = 6;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [CHAR_W-1:0] UPPER_SLOT_BASE = 8'd10;
    localparam logic [CHAR_W-1:0] LOWER_SLOT_BASE = 8'd36;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic checked;
        logic ok;
        logic scanning;
    } alpha_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic symbol_ok(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
               ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
    endfunction

    // Map a legal symbol onto a dense slot: digits, then upper, then lower case.
    function automatic logic [SLOT_W-1:0] symbol_slot(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] s;
        if (c <= CHAR_DIGIT_9)
        begin
            s = c - CHAR_DIGIT_0;
        end
        else if (c <= CHAR_UPPER_Z)
        begin
            s = c - CHAR_UPPER_A + UPPER_SLOT_BASE;
        end
        else
        begin
            s = c - CHAR_LOWER_A + LOWER_SLOT_BASE;
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ===== design/sitrt_alphabet.sv =====
// Alphabet register file with a one-symbol-per-cycle validity scan, held during register writes.
// Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_alphabet #(
    parameter int ALPHABET_BYTES = sitrt_pkg::ALPHABET_BYTES_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_write,
    input  logic [sitrt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [sitrt_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                      check_start,
    input  logic [$clog2(ALPHABET_BYTES)-1:0]         read_idx,
    output logic [sitrt_pkg::CHAR_W-1:0]              read_char,
    output sitrt_pkg::alpha_status_t                  status,
    output logic [$clog2(ALPHABET_BYTES+1)-1:0]       base
);
    import sitrt_pkg::*;

    localparam int WORD_COUNT = (ALPHABET_BYTES + 7) / 8;
    localparam int WORD_SEL_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BYTE_IDX_W = $clog2(ALPHABET_BYTES);
    localparam int SCAN_W     = $clog2(ALPHABET_BYTES + 1);

    logic [CFG_DATA_W-1:0] words_reg [WORD_COUNT];

    logic                  scanning_reg, scanning_next;
    logic                  checked_reg, checked_next;
    logic                  ok_reg, ok_next;
    logic [SCAN_W-1:0]     base_reg, base_next;
    logic [SCAN_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [SLOT_COUNT-1:0] seen_reg, seen_next;

    logic [BYTE_IDX_W-1:0] addr;
    logic [WORD_SEL_W-1:0] word_sel;
    logic [2:0]            byte_sel;
    logic [CFG_DATA_W-1:0] word;
    logic [CHAR_W-1:0]     sym;
    logic [SLOT_W-1:0]     slot;
    logic                  at_end;

    // Share the single read port between the scan and the emitter.
    assign addr     = scanning_reg ? scan_idx_reg[BYTE_IDX_W-1:0] : read_idx;
    assign word_sel = WORD_SEL_W'(addr >> 3);
    assign byte_sel = addr[2:0];
    assign word     = words_reg[word_sel];
    assign sym      = word[byte_sel*8 +: 8];
    assign read_char = sym;

    assign slot   = symbol_slot(sym);
    assign at_end = (scan_idx_reg == SCAN_W'(ALPHABET_BYTES)) || (sym == CHAR_NUL);

    // Clear the alphabet on reset so it reads as empty until written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                words_reg[w] <= '0;
            end
        end
        else if (cfg_write && ({1'b0, cfg_index} < (CFG_INDEX_W + 1)'(WORD_COUNT)))
        begin
            words_reg[WORD_SEL_W'(cfg_index)] <= cfg_data;
        end
    end

    always_comb
    begin
        scanning_next = scanning_reg;
        checked_next  = checked_reg;
        ok_next       = ok_reg;
        base_next     = base_reg;
        scan_idx_next = scan_idx_reg;
        seen_next     = seen_reg;

        if (cfg_write)
        begin
            checked_next = 1'b0;
        end
        else if (check_start)
        begin
            scanning_next = 1'b1;
            scan_idx_next = '0;
            seen_next     = '0;
        end
        else if (scanning_reg)
        begin
            if (at_end)
            begin
                scanning_next = 1'b0;
                checked_next  = 1'b1;
                ok_next       = (scan_idx_reg >= SCAN_W'(2));
                base_next     = scan_idx_reg;
            end
            else if (!symbol_ok(sym) || seen_reg[slot])
            begin
                scanning_next = 1'b0;
                checked_next  = 1'b1;
                ok_next       = 1'b0;
            end
            else
            begin
                seen_next[slot] = 1'b1;
                scan_idx_next   = scan_idx_reg + SCAN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            checked_reg  <= 1'b0;
            ok_reg       <= 1'b0;
            base_reg     <= '0;
        end
        else
        begin
            scanning_reg <= scanning_next;
            checked_reg  <= checked_next;
            ok_reg       <= ok_next;
            base_reg     <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        seen_reg     <= seen_next;
    end

    assign status.checked  = checked_reg;
    assign status.ok       = ok_reg;
    assign status.scanning = scanning_reg;
    assign base            = base_reg;

endmodule

// ===== design/sitrt_divider.sv =====
// Shared iterative divider: restoring division, DIV_STEPS quotient bits a cycle.
// Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_divider #(
    parameter int VALUE_WIDTH    = sitrt_pkg::VALUE_WIDTH_DEF,
    parameter int ALPHABET_BYTES = sitrt_pkg::ALPHABET_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [VALUE_WIDTH-1:0]                dividend,
    input  logic [$clog2(ALPHABET_BYTES+1)-1:0]   base,
    output sitrt_pkg::div_status_t                status,
    output logic [VALUE_WIDTH-1:0]                quotient,
    output logic [$clog2(ALPHABET_BYTES)-1:0]     remainder
);
    import sitrt_pkg::*;

    localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W      = DIV_CYCLES * DIV_STEPS;
    localparam int DIGIT_W    = $clog2(ALPHABET_BYTES);
    localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

    logic [PAD_W-1:0]   a_reg, a_next;
    logic [DIGIT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [PAD_W-1:0]   a_work;
    logic [DIGIT_W-1:0] r_work;
    logic [DIGIT_W:0]   base_ext;

    assign base_ext = (DIGIT_W + 1)'(base);

    always_comb
    begin
        logic [DIGIT_W:0] trial;
        a_work = a_reg;
        r_work = r_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial  = {r_work, a_work[PAD_W-1]};
            a_work = {a_work[PAD_W-2:0], 1'b0};
            if (trial >= base_ext)
            begin
                r_work    = DIGIT_W'(trial - base_ext);
                a_work[0] = 1'b1;
            end
            else
            begin
                r_work = trial[DIGIT_W-1:0];
            end
        end
    end

    always_comb
    begin
        a_next    = a_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            a_next    = PAD_W'(dividend);
            r_next    = '0;
            cnt_next  = CNT_W'(DIV_CYCLES);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next   = a_work;
            r_next   = r_work;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        r_reg <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = a_reg[VALUE_WIDTH-1:0];
    assign remainder   = r_reg;

endmodule

// ===== design/sitrt_ctrl.sv =====
// Sequencer: takes a value, drives the divider per digit, stacks the digits
// and emits the text through an output register. Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_ctrl #(
    parameter int VALUE_WIDTH    = sitrt_pkg::VALUE_WIDTH_DEF,
    parameter int ALPHABET_BYTES = sitrt_pkg::ALPHABET_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sitrt_pkg::VALUE_PORT_W-1:0]    value,
    output logic                                  check_start,
    input  sitrt_pkg::alpha_status_t              alpha_status,
    output logic                                  div_start,
    output logic [VALUE_WIDTH-1:0]                div_dividend,
    input  sitrt_pkg::div_status_t                div_status,
    input  logic [VALUE_WIDTH-1:0]                div_quotient,
    input  logic [$clog2(ALPHABET_BYTES)-1:0]     div_remainder,
    output logic [$clog2(ALPHABET_BYTES)-1:0]     read_idx,
    input  logic [sitrt_pkg::CHAR_W-1:0]          read_char,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sitrt_pkg::CHAR_W-1:0]          character,
    output logic                                  last
);
    import sitrt_pkg::*;

    localparam int DIGIT_W     = $clog2(ALPHABET_BYTES);
    localparam int DEPTH_W     = $clog2(VALUE_WIDTH + 1);
    localparam int DEPTH_IDX_W = $clog2(VALUE_WIDTH);

    ctrl_state_t        state_reg, state_next;
    logic               sign_pend_reg, sign_pend_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic [DIGIT_W-1:0] digits_reg [VALUE_WIDTH];
    logic               push;

    logic [VALUE_WIDTH-1:0] raw;
    logic [DEPTH_W-1:0]     top;
    logic                   load_ok;

    assign raw      = value[VALUE_WIDTH-1:0];
    assign top      = depth_reg - DEPTH_W'(1);
    assign read_idx = digits_reg[top[DEPTH_IDX_W-1:0]];
    assign load_ok  = !out_valid_reg || !out_stall;

    assign in_stall     = (state_reg != ST_IDLE);
    assign div_dividend = (state_reg == ST_PREP) ? mag_reg : div_quotient;

    always_comb
    begin
        state_next     = state_reg;
        sign_pend_next = sign_pend_reg;
        mag_next       = mag_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        check_start    = 1'b0;
        div_start      = 1'b0;
        push           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sign_pend_next = raw[VALUE_WIDTH-1];
                    mag_next       = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    depth_next     = '0;
                    state_next     = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (!alpha_status.checked)
                begin
                    check_start = 1'b1;
                    state_next  = ST_CHECK;
                end
                else if (!alpha_status.ok)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_CHECK:
            begin
                if (alpha_status.checked)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    push       = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                    if (div_quotient == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        char_next      = CHAR_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next  = read_char;
                        last_next  = (depth_reg == DEPTH_W'(1));
                        depth_next = top;
                        if (depth_reg == DEPTH_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_pend_reg <= 1'b0;
            depth_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_pend_reg <= sign_pend_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (push)
        begin
            digits_reg[depth_reg[DEPTH_IDX_W-1:0]] <= div_remainder;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

// ===== design/signed_int_to_radix_text_unit.sv =====
// Each accepted request converts a signed VALUE_WIDTH-bit value (low bits of
// the value port, two's complement) into text whose digits come from the
// configured alphabet; the base is the alphabet length. Negative values start
// with '-', the most negative value is exact, zero gives the first symbol, and
// an invalid alphabet (fewer than two symbols, a symbol outside A-Z, a-z,
// 0-9, or a repeat) drops the request with no output. One character leaves per
// output request, with last on the final one. The block handles one request
// at a time: it registers the value; after any register write, the next
// request also pays an alphabet scan (one symbol a cycle, held while a
// register is written) before the divider starts; then the shared divider,
// which retires eight quotient bits a cycle, produces each digit; then one
// character a cycle enters the output register while the consumer keeps up.
`timescale 1ns / 1ps
`include "signed_int_to_radix_text_unit_assert.svh"

module signed_int_to_radix_text_unit #(
    parameter int ALPHABET_BYTES = sitrt_pkg::ALPHABET_BYTES_DEF,
    parameter int VALUE_WIDTH    = sitrt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write,
    input  logic [sitrt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sitrt_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sitrt_pkg::VALUE_PORT_W-1:0]    value,
    // output request channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sitrt_pkg::CHAR_W-1:0]          character,
    output logic                                  last
);
    import sitrt_pkg::*;

    localparam int BYTE_IDX_W = $clog2(ALPHABET_BYTES);
    localparam int BASE_W     = $clog2(ALPHABET_BYTES + 1);

    alpha_status_t          alpha_stat;
    div_status_t            div_stat;
    logic [BASE_W-1:0]      base;
    logic                   check_start;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [BYTE_IDX_W-1:0]  div_remainder;
    logic [BYTE_IDX_W-1:0]  read_idx;
    logic [CHAR_W-1:0]      read_char;

    // Alphabet registers; validity and base are cached until the next write.
    sitrt_alphabet #(
        .ALPHABET_BYTES (ALPHABET_BYTES)
    ) u_alphabet (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .check_start (check_start),
        .read_idx    (read_idx),
        .read_char   (read_char),
        .status      (alpha_stat),
        .base        (base)
    );

    // One divider produces every digit, least significant first.
    sitrt_divider #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .ALPHABET_BYTES (ALPHABET_BYTES)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .base      (base),
        .status    (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Sequence the request, stack the digits and pop them out in print order.
    sitrt_ctrl #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .ALPHABET_BYTES (ALPHABET_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .check_start   (check_start),
        .alpha_status  (alpha_stat),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_status    (div_stat),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .read_idx      (read_idx),
        .read_char     (read_char),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .character     (character),
        .last          (last)
    );

    // A new request only lands while neither the scan nor the divider is busy.
    `SITRT_ASSERT_SAME(a_accept_when_quiet, in_valid && !in_stall, !div_stat.busy && !alpha_stat.scanning)
    // The scan and the divider never run together.
    `SITRT_ASSERT_SAME(a_scan_excludes_div, alpha_stat.scanning, !div_stat.busy)
    // A minus sign is always followed by at least one digit.
    `SITRT_ASSERT_SAME(a_minus_not_last, out_valid && (character == CHAR_MINUS), !last)
    // Divider completion is a single-cycle pulse.
    `SITRT_ASSERT_NEXT(a_done_pulse, div_stat.done, !div_stat.done)

endmodule

// ===== dv/signed_int_to_radix_text_unit_test.sv =====
// Self-checking testbench for the signed integer to radix text unit.
// Depends on sitrt_pkg and signed_int_to_radix_text_unit; reads no files.
`timescale 1ns / 1ps

module signed_int_to_radix_text_unit_test;
    import sitrt_pkg::*;

    // Block geometry at its default parameters.
    localparam int ALPHA_BYTES  = ALPHABET_BYTES_DEF;
    localparam int VALUE_BITS   = VALUE_WIDTH_DEF;
    localparam int ALPHA_WORDS  = ALPHA_BYTES / 8;
    localparam int LEGAL_COUNT  = 62;

    // Alphabet word i sits at register index REG_ALPHA_WORD_0 + i.
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_WORD_0 = '0;

    // Worst request: alphabet scan with handoff, register, 32 digits and a
    // sign, plus output stalls. Quiet and tail windows cover that.
    localparam int QUIET_CYCLES = 300;
    localparam int TAIL_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 300;
    localparam int MAX_REPORTS  = 100;

    // One character of expected text.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } text_char_t;

    typedef enum logic [1:0] {
        ROW_SET_ALPHABET,   // load the alphabet given in text
        ROW_LITERAL,        // send value, expect exactly text
        ROW_PREDICTED       // send value, expect what the predictor computes
    } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [VALUE_PORT_W-1:0]  value;
        string                    text;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [VALUE_PORT_W-1:0]  value;
    logic                     out_valid;
    logic                     out_stall;
    logic [CHAR_W-1:0]        character;
    logic                     last;

    // Predictor copy of the alphabet registers and the text still owed.
    logic [CFG_DATA_W-1:0]    alpha_words [ALPHA_WORDS];
    text_char_t               pending_text [$];
    text_char_t               seen_char;

    int error_count  = 0;
    int report_count = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;

    // Directed part: reset state, both radix extremes, every reject reason.
    stim_row_t directed_rows [28] = '{
        '{ROW_LITERAL,      32'd5,           ""},
        '{ROW_LITERAL,      -32'sd7,         ""},
        '{ROW_SET_ALPHABET, '0,              "0123456789"},
        '{ROW_LITERAL,      32'd0,           "0"},
        '{ROW_LITERAL,      32'h7FFF_FFFF,   "2147483647"},
        '{ROW_LITERAL,      32'h8000_0000,   "-2147483648"},
        '{ROW_LITERAL,      32'hFFFF_FFFF,   "-1"},
        '{ROW_PREDICTED,    32'd90210,       ""},
        '{ROW_SET_ALPHABET, '0,              "01"},
        '{ROW_PREDICTED,    32'h8000_0000,   ""},
        '{ROW_PREDICTED,    32'h7FFF_FFFF,   ""},
        '{ROW_LITERAL,      32'd0,           "0"},
        '{ROW_LITERAL,      32'hFFFF_FFFF,   "-1"},
        '{ROW_SET_ALPHABET, '0,
          "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz"},
        '{ROW_LITERAL,      32'd61,          "z"},
        '{ROW_LITERAL,      32'd62,          "10"},
        '{ROW_PREDICTED,    32'h8000_0000,   ""},
        '{ROW_PREDICTED,    32'h7FFF_FFFF,   ""},
        '{ROW_SET_ALPHABET, '0,              "A"},
        '{ROW_LITERAL,      32'd1,           ""},
        '{ROW_SET_ALPHABET, '0,              "01-"},
        '{ROW_LITERAL,      32'd3,           ""},
        '{ROW_SET_ALPHABET, '0,              "0120"},
        '{ROW_LITERAL,      32'd3,           ""},
        // all 64 bytes filled, so no terminator; the last two repeat
        '{ROW_SET_ALPHABET, '0,
          "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz01"},
        '{ROW_LITERAL,      32'd3,           ""},
        '{ROW_SET_ALPHABET, '0,              "zQ7k"},
        '{ROW_PREDICTED,    -32'sd12345,     ""}
    };

    signed_int_to_radix_text_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] alpha_byte(input int k);
        return alpha_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic bit legal_symbol(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    // Radix of the configured alphabet, or 0 when the alphabet is rejected.
    function automatic int radix_of_alphabet();
        int len;
        len = 0;
        while (len < ALPHA_BYTES && alpha_byte(len) != CHAR_NUL)
            len++;
        if (len < 2)
            return 0;
        for (int i = 0; i < len; i++)
        begin
            if (!legal_symbol(alpha_byte(i)))
                return 0;
            for (int j = 0; j < i; j++)
                if (alpha_byte(j) == alpha_byte(i))
                    return 0;
        end
        return len;
    endfunction

    // Queue the text of one value: sign, then digits most significant first.
    function automatic void predict_text(input logic [VALUE_PORT_W-1:0] v);
        int          radix;
        logic [63:0] raw;
        logic [63:0] mag;
        int          digits [$];
        radix = radix_of_alphabet();
        if (radix == 0)
            return;
        raw = 64'(v) & ((64'd1 << VALUE_BITS) - 64'd1);
        if (raw[VALUE_BITS-1])
        begin
            pending_text.push_back('{CHAR_MINUS, 1'b0});
            mag = (64'd1 << VALUE_BITS) - raw;
        end
        else
        begin
            mag = raw;
        end
        do
        begin
            digits.push_front(int'(mag % 64'(radix)));
            mag = mag / 64'(radix);
        end
        while (mag != 0);
        foreach (digits[i])
            pending_text.push_back('{alpha_byte(digits[i]), i == digits.size() - 1});
    endfunction

    function automatic void expect_literal(input string text);
        for (int i = 0; i < text.len(); i++)
            pending_text.push_back('{text[i], i == text.len() - 1});
    endfunction

    // Print one line per mismatch (capped) and count every one.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (report_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        report_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Rewrite all alphabet words once the block has gone quiet. Bytes after
    // the terminator get random junk, which the block must ignore.
    task automatic load_alphabet(input string symbols);
        logic [7:0]            bytes_out [ALPHA_BYTES];
        logic [CFG_DATA_W-1:0] word;
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        // a rejected request may still be scanning after the last character
        repeat (QUIET_CYCLES) @(posedge clk);
        for (int k = 0; k < ALPHA_BYTES; k++)
        begin
            if (k < symbols.len())
                bytes_out[k] = symbols[k];
            else if (k == symbols.len())
                bytes_out[k] = CHAR_NUL;
            else
                bytes_out[k] = 8'($urandom_range(0, 255));
        end
        for (int w = 0; w < ALPHA_WORDS; w++)
        begin
            for (int b = 0; b < 8; b++)
                word[b * 8 +: 8] = bytes_out[w * 8 + b];
            cfg_write <= 1'b1;
            cfg_index <= REG_ALPHA_WORD_0 + CFG_INDEX_W'(w);
            cfg_data  <= word;
            @(posedge clk);
            alpha_words[w] = word;
        end
        cfg_write <= 1'b0;
    endtask

    // Offer one request, in bursts with random gaps; predict on acceptance.
    task automatic send_value(input logic [VALUE_PORT_W-1:0] v, input row_kind_t kind,
                              input string text);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (kind == ROW_LITERAL)
            expect_literal(text);
        else
            predict_text(v);
    endtask

    // Drop valid and hold off until every owed character has come out.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_text.size() != 0);
    endtask

    // Shuffle the legal symbols and take a prefix; for a rejected alphabet,
    // break it in one of the ways the block must catch.
    function automatic string random_alphabet(input bit want_valid);
        string pool;
        string s;
        byte   tmp;
        int    i;
        int    j;
        int    radix;
        pool = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        for (int k = LEGAL_COUNT - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
        end
        case ($urandom_range(0, 3))
            0:       radix = $urandom_range(2, 4);
            1:       radix = $urandom_range(50, LEGAL_COUNT);
            default: radix = $urandom_range(2, LEGAL_COUNT);
        endcase
        s = pool.substr(0, radix - 1);
        if (!want_valid)
        begin
            case ($urandom_range(0, 4))
                0: s = pool.substr(0, 0);
                1: s = "";
                2:
                begin
                    i = $urandom_range(0, radix - 1);
                    do
                        tmp = byte'($urandom_range(1, 255));
                    while (legal_symbol(tmp));
                    s[i] = tmp;
                end
                3:
                begin
                    j = $urandom_range(1, radix - 1);
                    i = $urandom_range(0, j - 1);
                    s[j] = s[i];
                end
                default: s = {pool, pool.substr(0, 1)};
            endcase
        end
        return s;
    endfunction

    // Mix of full-range values, short texts, extremes and radix powers.
    function automatic logic [VALUE_PORT_W-1:0] random_value(input int radix);
        logic [VALUE_PORT_W-1:0] v;
        logic [63:0]             p;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, radix * radix * radix);
            2: v = -VALUE_PORT_W'($urandom_range(1, radix * radix));
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
            4:
            begin
                p = 64'd1;
                repeat ($urandom_range(0, 31))
                    if (p * radix < 64'h8000_0000)
                        p = p * radix;
                v = VALUE_PORT_W'(p) - VALUE_PORT_W'($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Stall pattern: runs of free flow, coin flips, light stalls, hard stalls.
    initial
    begin
        int run_len;
        int mode;
        out_stall <= 1'b0;
        forever
        begin
            run_len = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (run_len)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    // Compare each accepted character with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          character, last));
            end
            else
            begin
                seen_char = pending_text.pop_front();
                if (character !== seen_char.code)
                    report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                              character, seen_char.code));
                if (last !== seen_char.fin)
                    report_mismatch($sformatf("last %0b, want %0b on character 0x%02h",
                                              last, seen_char.fin, seen_char.code));
            end
        end
    end

    // Watchdog: end the run when no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            idle_cycles = 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d characters owed",
                     IDLE_LIMIT, pending_text.size());
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int valid_items;
        int phase_idx;
        int phase_len;
        int pause_at;
        int radix;
        bit want_valid;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        value     <= '0;
        foreach (alpha_words[w])
            alpha_words[w] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: literal rows carry their own text, the rest predict.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_SET_ALPHABET)
                load_alphabet(directed_rows[r].text);
            else
                send_value(directed_rows[r].value, directed_rows[r].kind,
                           directed_rows[r].text);
        end

        // Random phases: mostly legal alphabets of random radix, now and then
        // a broken one. Only requests that produce text count toward the total.
        valid_items = 0;
        phase_idx = 0;
        while (valid_items < RANDOM_ITEMS)
        begin
            want_valid = (phase_idx == 0) || ($urandom_range(0, 5) != 0);
            load_alphabet(random_alphabet(want_valid));
            radix = radix_of_alphabet();
            phase_len = (radix == 0) ? $urandom_range(2, 5) : $urandom_range(10, 40);
            // the first phase always drains once mid-stream
            pause_at = (phase_idx == 0 || $urandom_range(0, 1)) ?
                       $urandom_range(1, phase_len - 1) : -1;
            for (int n = 0; n < phase_len; n++)
            begin
                if (n == pause_at)
                    hold_until_drained();
                send_value(random_value(radix == 0 ? 10 : radix), ROW_PREDICTED, "");
            end
            if (radix != 0)
                valid_items += phase_len;
            phase_idx++;
        end

        // Drain, then give stray characters a chance to show up.
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
